// ===== rtl/core/mrwr_pkg.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin round package
// Shared types and constants for the witness round controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package mrwr_pkg;
	localparam logic [1:0] VERDICT_PRIME     = 2'd0;
	localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
	localparam logic [1:0] VERDICT_BAD_BASE  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_STRIP, ST_POW_BIT, ST_MUL_R, ST_MUL_B, ST_SHIFT_E,
		ST_CHECK, ST_SQUARE, ST_SQ_CHECK, ST_DONE
	} mrwr_state_t;

	// datapath operation selects
	typedef enum logic [2:0] {
		OP_NONE, OP_LOAD, OP_STRIP, OP_MUL_START, OP_SHIFT_E, OP_SQ_START
	} mrwr_op_t;

	typedef struct packed {
		mrwr_op_t op;
		logic     mul_to_r;  // product goes to result register, else to base
	} mrwr_cmd_t;

	typedef struct packed {
		logic [1:0] early;     // verdict settled before any test
		logic       early_hit;
		logic       d_odd;
		logic       e_zero;
		logic       e_lsb;
		logic       mul_busy;
		logic       x_one;
		logic       x_nm1;
		logic       s_left;    // squarings remain
	} mrwr_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/mrwr_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface mrwr_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mrwr_datapath.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin datapath
// Operand registers, bit-serial modular multiplier and status compares.
// ----------------------------------------------------------------------------
`default_nettype none
module mrwr_datapath #(
	parameter int WIDTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [WIDTH-1:0]    cand,
	input  wire logic [WIDTH-1:0]    base,
	input  mrwr_pkg::mrwr_cmd_t      cmd,
	output mrwr_pkg::mrwr_sts_t      sts
);
	import mrwr_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] n_q, nm1_q, d_q, r_q, b_q;
	logic [CW-1:0]    s_q;
	logic [WIDTH-1:0] acc_q, mx_q, my_q;
	logic [CW-1:0]    bit_q;
	logic             busy_q, to_r_q;

	logic [WIDTH-1:0] dbl, addx;
	logic [WIDTH:0]   sum1, sum2;
	logic             base_bad;

	// acc = 2*acc mod n, then + x mod n
	always_comb begin
		sum1 = {1'b0, acc_q} + {1'b0, acc_q};
		dbl  = (sum1 >= {1'b0, n_q}) ? sum1[WIDTH-1:0] - n_q : sum1[WIDTH-1:0];
		sum2 = {1'b0, dbl} + {1'b0, mx_q};
		addx = (sum2 >= {1'b0, n_q}) ? sum2[WIDTH-1:0] - n_q : sum2[WIDTH-1:0];
	end

	// early verdicts from the raw candidate and base
	always_comb begin
		base_bad = (base < WIDTH'(2)) || (base > cand - WIDTH'(2));
		sts.early     = VERDICT_COMPOSITE;
		sts.early_hit = 1'b1;
		if (cand < WIDTH'(2))
			sts.early = VERDICT_COMPOSITE;
		else if (cand == WIDTH'(2) || cand == WIDTH'(3))
			sts.early = VERDICT_PRIME;
		else if (!cand[0])
			sts.early = VERDICT_COMPOSITE;
		else if (base_bad)
			sts.early = VERDICT_BAD_BASE;
		else
			sts.early_hit = 1'b0;
		sts.d_odd    = d_q[0];
		sts.e_zero   = (d_q == '0);
		sts.e_lsb    = d_q[0];
		sts.mul_busy = busy_q;
		sts.x_one    = (r_q == WIDTH'(1));
		sts.x_nm1    = (r_q == nm1_q);
		sts.s_left   = (s_q > CW'(1));
	end

	// operand registers and multiplier sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			to_r_q <= 1'b0;
			n_q    <= '0;
			nm1_q  <= '0;
			d_q    <= '0;
			r_q    <= '0;
			b_q    <= '0;
			s_q    <= '0;
			acc_q  <= '0;
			mx_q   <= '0;
			my_q   <= '0;
			bit_q  <= '0;
		end else begin
			if (busy_q) begin
				acc_q <= my_q[bit_q[$clog2(WIDTH)-1:0]] ? addx : dbl;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					if (to_r_q)
						r_q <= my_q[0] ? addx : dbl;
					else
						b_q <= my_q[0] ? addx : dbl;
				end
				bit_q <= bit_q - CW'(1);
			end
			case (cmd.op)
				OP_LOAD: begin
					n_q   <= cand;
					nm1_q <= cand - WIDTH'(1);
					d_q   <= cand - WIDTH'(1);
					b_q   <= base;
					r_q   <= WIDTH'(1);
					s_q   <= '0;
				end
				OP_STRIP: begin
					d_q <= d_q >> 1;
					s_q <= s_q + CW'(1);
				end
				OP_MUL_START: begin
					busy_q <= 1'b1;
					to_r_q <= cmd.mul_to_r;
					acc_q  <= '0;
					bit_q  <= CW'(WIDTH - 1);
					mx_q   <= cmd.mul_to_r ? r_q : b_q;
					my_q   <= b_q;
				end
				OP_SQ_START: begin
					busy_q <= 1'b1;
					to_r_q <= 1'b1;
					acc_q  <= '0;
					bit_q  <= CW'(WIDTH - 1);
					mx_q   <= r_q;
					my_q   <= r_q;
					s_q    <= s_q - CW'(1);
				end
				OP_SHIFT_E: d_q <= d_q >> 1;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/mrwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin controller
// Sequences the strip, exponentiation and squaring steps of one round.
// ----------------------------------------------------------------------------
`default_nettype none
module mrwr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           verdict,
	input  mrwr_pkg::mrwr_sts_t  sts,
	output mrwr_pkg::mrwr_cmd_t  cmd
);
	import mrwr_pkg::*;

	mrwr_state_t state_q, state_d;
	logic [1:0]  verdict_q, verdict_d;

	// hold state and verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			verdict_q <= VERDICT_PRIME;
		end else begin
			state_q   <= state_d;
			verdict_q <= verdict_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		verdict_d = verdict_q;
		cmd.op       = OP_NONE;
		cmd.mul_to_r = 1'b0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (sts.early_hit) begin
						verdict_d = sts.early;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_STRIP;
					end
				end
			end
			ST_STRIP: begin
				if (sts.d_odd) state_d = ST_POW_BIT;
				else cmd.op = OP_STRIP;
			end
			ST_POW_BIT: begin
				if (sts.e_zero) state_d = ST_CHECK;
				else if (sts.e_lsb) begin
					cmd.op = OP_MUL_START; cmd.mul_to_r = 1'b1; state_d = ST_MUL_R;
				end else begin
					cmd.op = OP_MUL_START; state_d = ST_MUL_B;
				end
			end
			ST_MUL_R: begin
				if (!sts.mul_busy) begin
					cmd.op = OP_MUL_START; state_d = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				if (!sts.mul_busy) begin
					cmd.op = OP_SHIFT_E; state_d = ST_POW_BIT;
				end
			end
			ST_CHECK: begin
				if (sts.x_one || sts.x_nm1) begin
					verdict_d = VERDICT_PRIME; state_d = ST_DONE;
				end else if (sts.s_left) begin
					cmd.op = OP_SQ_START; state_d = ST_SQUARE;
				end else begin
					verdict_d = VERDICT_COMPOSITE; state_d = ST_DONE;
				end
			end
			ST_SQUARE: if (!sts.mul_busy) state_d = ST_SQ_CHECK;
			ST_SQ_CHECK: begin
				if (sts.x_nm1) begin
					verdict_d = VERDICT_PRIME; state_d = ST_DONE;
				end else if (sts.x_one || !sts.s_left) begin
					verdict_d = VERDICT_COMPOSITE; state_d = ST_DONE;
				end else begin
					cmd.op = OP_SQ_START; state_d = ST_SQUARE;
				end
			end
			ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		verdict = verdict_q;
	end
endmodule
`default_nettype wire

// ===== rtl/core/miller_rabin_witness_round.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness round
// One primality round per item: candidate and base in, verdict out.
// ----------------------------------------------------------------------------
// One item at a time. A round takes about (2*bits(d) + s) modular products from
// the bit-serial shift-and-add multiplier, plus the steps that strip n-1.
// Trivial candidates and bad bases go straight to the verdict, with no product.
`default_nettype none
module miller_rabin_witness_round #(
	parameter int WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mrwr_stream_if.sink   in_item,
	mrwr_stream_if.source out_item
);
	import mrwr_pkg::*;

	mrwr_cmd_t cmd;
	mrwr_sts_t sts;
	logic [WIDTH-1:0] cand, base;

	assign cand = in_item.data[WIDTH-1:0];
	assign base = in_item.data[64+WIDTH-1:64];

	mrwr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_item.valid), .in_ready(in_item.ready),
		.out_valid(out_item.valid), .out_ready(out_item.ready),
		.verdict(out_item.data), .sts(sts), .cmd(cmd)
	);

	mrwr_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cand(cand), .base(base),
		.cmd(cmd), .sts(sts)
	);
endmodule
`default_nettype wire

// ===== tb/mrwr_round_checker.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin round checker
// Watches the input and output channels of the witness round, predicts the
// verdict of each accepted item and compares it with the item that comes out.
// ----------------------------------------------------------------------------
`default_nettype none
module mrwr_round_checker #(
	parameter int WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mrwr_stream_if    in_item,
	mrwr_stream_if    out_item,
	output int        fails,
	output int        pending,
	output int        verdicts_seen [3]
);
	import mrwr_pkg::*;

	logic [1:0] verdict_due [$];

	// modular product over full-width operands
	function automatic logic [WIDTH-1:0] prod_mod(logic [WIDTH-1:0] x, logic [WIDTH-1:0] y,
			logic [WIDTH-1:0] m);
		logic [2*WIDTH-1:0] wide;
		wide = ({{WIDTH{1'b0}}, x} * {{WIDTH{1'b0}}, y}) % {{WIDTH{1'b0}}, m};
		return wide[WIDTH-1:0];
	endfunction

	// verdict of one round for candidate n and base a
	function automatic logic [1:0] round_verdict(logic [WIDTH-1:0] n, logic [WIDTH-1:0] a);
		logic [WIDTH-1:0] odd_part, x, nm1, sq_base, e;
		int               twos;
		if (n < 2)
			return VERDICT_COMPOSITE;
		if (n == 2 || n == 3)
			return VERDICT_PRIME;
		if (!n[0])
			return VERDICT_COMPOSITE;
		nm1 = n - 1;
		if (a < 2 || a > n - 2)
			return VERDICT_BAD_BASE;
		odd_part = nm1;
		twos = 0;
		while (!odd_part[0]) begin
			odd_part = odd_part >> 1;
			twos++;
		end
		x = 1;
		sq_base = a;
		e = odd_part;
		while (e != 0) begin
			if (e[0])
				x = prod_mod(x, sq_base, n);
			sq_base = prod_mod(sq_base, sq_base, n);
			e = e >> 1;
		end
		if (x == 1 || x == nm1)
			return VERDICT_PRIME;
		for (int i = 1; i < twos; i++) begin
			x = prod_mod(x, x, n);
			if (x == nm1)
				return VERDICT_PRIME;
			if (x == 1)
				return VERDICT_COMPOSITE;
		end
		return VERDICT_COMPOSITE;
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $time, what);
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
		foreach (verdicts_seen[i])
			verdicts_seen[i] = 0;
	end

	// predict on input, compare on output
	always @(posedge clk) begin
		logic [1:0] want;
		if (arst_n) begin
			if (in_item.valid && in_item.ready)
				verdict_due.push_back(round_verdict(in_item.data[WIDTH-1:0],
					in_item.data[64+WIDTH-1:64]));
			if (out_item.valid && out_item.ready) begin
				if (verdict_due.size() == 0) begin
					report($sformatf("verdict %0d with no item outstanding", out_item.data));
				end else begin
					want = verdict_due.pop_front();
					if (out_item.data !== want)
						report($sformatf("verdict %0d, expected %0d", out_item.data, want));
					if (want < 3)
						verdicts_seen[want]++;
				end
			end
			pending <= verdict_due.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness round testbench
// Drives directed and random rounds with random idling on both channels and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	import mrwr_pkg::*;

	localparam int WIDTH = 64;
	localparam int STALL_LIMIT = 60000;
	localparam int RANDOM_ITEMS = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic steady = 1'b0;
	int   fails, pending, sent, quiet;
	int   verdicts_seen [3];

	mrwr_stream_if #(.W(2*WIDTH)) in_item ();
	mrwr_stream_if #(.W(2)) out_item ();

	miller_rabin_witness_round #(.WIDTH(WIDTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.out_item(out_item)
	);

	mrwr_round_checker #(.WIDTH(WIDTH)) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.out_item(out_item),
		.fails(fails),
		.pending(pending),
		.verdicts_seen(verdicts_seen)
	);

	always #1 clk = ~clk;

	initial begin
		in_item.valid = 1'b0;
		in_item.data = '0;
		out_item.ready = 1'b0;
	end

	// stall the output side at random, except in the steady stretch
	always @(posedge clk) begin
		out_item.ready <= steady || ($urandom_range(99) >= 12);
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [WIDTH-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// hold one item until it is accepted, with an optional idle gap first
	task automatic send_round(logic [WIDTH-1:0] n, logic [WIDTH-1:0] a);
		if (!steady && $urandom_range(99) < 12) begin
			in_item.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_item.valid <= 1'b1;
		in_item.data <= {a, n};
		do
			@(posedge clk);
		while (!in_item.ready);
		sent++;
	endtask

	logic [WIDTH-1:0] primes [6] = '{64'd97, 64'd65521, 64'd4294967291, 64'd1000000007,
		64'd2305843009213693951, 64'd18446744073709551557};
	logic [WIDTH-1:0] pseudo [4] = '{64'd2047, 64'd3215031751, 64'd561, 64'd1105};

	initial begin
		logic [WIDTH-1:0] n, a, mask;
		int               pick;
		quiet = 0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: trivial candidates, range edges, special paths
		send_round(64'd0, rand_word());
		send_round(64'd1, 64'd0);
		send_round(64'd2, 64'd5);
		send_round(64'd3, '1);
		send_round(64'd4, 64'd2);
		send_round(64'hFFFF_FFFF_FFFF_FFFE, 64'd3);
		send_round(64'd5, 64'd1);
		send_round(64'd5, 64'd2);
		send_round(64'd5, 64'd3);
		send_round(64'd5, 64'd4);
		send_round(64'd7, '0);
		send_round(64'd9, 64'd8);
		send_round(64'd25, 64'd7);
		send_round(64'd561, 64'd2);
		send_round(64'd2047, 64'd2);
		send_round(64'd15, 64'd2);
		send_round('1, 64'd2);
		send_round('1, 64'hFFFF_FFFF_FFFF_FFFD);
		send_round('1, 64'hFFFF_FFFF_FFFF_FFFE);
		send_round(64'd18446744073709551557, 64'd18446744073709551555);
		send_round(64'd18446744073709551557, 64'h5555_AAAA_3333_CCCC);

		// random: mostly well-formed rounds of mixed size, some primes, some noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 30 && i < 50);
			pick = $urandom_range(99);
			if (pick < 15) begin
				n = primes[$urandom_range(5)];
			end else if (pick < 25) begin
				n = pseudo[$urandom_range(3)];
			end else begin
				mask = '1 >> (WIDTH - $urandom_range(3, WIDTH));
				n = rand_word() & mask;
				n[0] = 1'b1;
				if (n < 5)
					n = 64'd5;
			end
			a = 2 + rand_word() % (n - 3);
			if (pick >= 88)
				a = rand_word();
			if (pick >= 95)
				n = rand_word();
			send_round(n, a);
		end
		steady = 1'b0;
		in_item.valid <= 1'b0;

		// let the last item reach the checker, drain, then let the block settle
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d rounds sent: %0d probable prime, %0d composite, %0d bad base",
			sent, verdicts_seen[VERDICT_PRIME], verdicts_seen[VERDICT_COMPOSITE],
			verdicts_seen[VERDICT_BAD_BASE]);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
